// ===== rtl/ppb_pkg.sv =====
package ppb_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_FILL    = 2'd0;
    localparam logic [1:0] CMD_UPDATE  = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_PACKET_GAP   = 2'd0;
    localparam logic [1:0] REG_FRAME_FACTOR = 2'd1;
    localparam logic [1:0] REG_BUDGET_MARGIN = 2'd2;

    localparam logic [7:0] PACKET_GAP_RESET    = 8'd5;
    localparam logic [9:0] FRAME_FACTOR_RESET  = 10'd307;
    localparam logic [9:0] BUDGET_MARGIN_RESET = 10'd384;

    localparam int BUDGET_W = 34;
    localparam int REFILL_W = 33;
    localparam logic signed [BUDGET_W-1:0] BUDGET_MAX = {1'b0, {(BUDGET_W-1){1'b1}}};
    localparam logic signed [BUDGET_W-1:0] BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [15:0] seq_num;
        logic [31:0] frame_stamp;
        logic [15:0] packet_bytes;
        logic [31:0] interval_ms;
        logic [15:0] rate_kbps;
    } in_t;

    typedef struct packed {
        logic        sent;
        logic [15:0] sent_seq;
        logic        queue_empty;
        logic        dropped;
    } out_t;

    typedef struct packed {
        logic [7:0] packet_gap_ms;
        logic [9:0] frame_factor_q8;
        logic [9:0] budget_margin_q8;
    } cfg_t;

    // Decoded operation, one bit per command
    typedef struct packed {
        logic fill;
        logic update;
        logic request;
        logic clear;
    } op_t;

    typedef struct packed {
        op_t op;
        in_t item;
    } job_t;

    // One queued packet
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [15:0] len;
        logic [31:0] stored;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic bytes_zero;
    } stat_t;

    // Clamp a 35-bit signed value into the 34-bit budget range
    function automatic logic signed [BUDGET_W-1:0] sat_budget(input logic signed [BUDGET_W:0] v);
        logic signed [BUDGET_W-1:0] r;
        if (v[BUDGET_W] != v[BUDGET_W-1])
        begin
            r = v[BUDGET_W] ? BUDGET_MIN : BUDGET_MAX;
        end
        else
        begin
            r = v[BUDGET_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppb_ram.sv =====
module ppb_ram
    #(
        parameter int WIDTH = 96,
        parameter int DEPTH = 64
    )
    (
        input  logic                     clk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic                     rd_en,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ppb_front.sv =====
module ppb_front
    import ppb_pkg::*;
    (
        input  logic clk,
        input  logic rst_n,
        input  logic in_valid,
        output logic in_ready,
        input  in_t  in_data,
        output logic job_valid,
        input  logic job_ready,
        output job_t job
    );

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    op_t        op_c;

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    // Classify the incoming command
    always_comb
    begin
        op_c = '0;
        case (in_data.command)
            CMD_FILL:    op_c.fill    = 1'b1;
            CMD_UPDATE:  op_c.update  = 1'b1;
            CMD_REQUEST: op_c.request = 1'b1;
            CMD_CLEAR:   op_c.clear   = 1'b1;
            default:     op_c.clear   = 1'b1;
        endcase
    end

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold the classified beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op_c, item: in_data};
        end
    end

endmodule

// ===== rtl/ppb_back.sv =====
module ppb_back
    import ppb_pkg::*;
    #(
        parameter int QUEUE_DEPTH = 64
    )
    (
        input  logic  clk,
        input  logic  rst_n,
        input  logic  job_valid,
        output logic  job_ready,
        input  job_t  job,
        input  cfg_t  cfg,
        output logic  out_valid,
        input  logic  out_ready,
        output out_t  out_data,
        output stat_t stat
    );

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTES_W = 16 + CNT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    job_t                       job_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [BYTES_W-1:0]         bytes_reg, bytes_next;
    logic signed [BUDGET_W-1:0] budget_reg, budget_next;
    logic [31:0]                last_stamp_reg, last_stamp_next;
    logic [15:0]                last_len_reg, last_len_next;
    logic [31:0]                last_stored_reg, last_stored_next;
    logic [31:0]                last_sent_reg, last_sent_next;
    logic [47:0]                mul_reg;
    logic [REFILL_W-1:0]        refill_reg;
    logic [41:0]                prod_reg;
    logic                       out_valid_reg, out_valid_next;
    out_t                       out_data_reg, out_data_next;

    logic [47:0]        base_prod;
    logic [54:0]        scale_prod;
    logic [REFILL_W-1:0] refill_c;
    logic [31:0]        diff;
    logic [41:0]        fac_prod;
    pkt_t               head_pkt;
    logic               ram_rd_en;
    logic               ram_wr_en;
    pkt_t               ram_wr_data;
    logic [CNT_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic               out_free;
    logic               done_go;
    logic               full;
    logic               can_send;
    logic               ok;
    logic [31:0]        elapsed;
    logic               gap_ok;
    logic               fac_ok;
    logic [BYTES_W-1:0] len_ext;

    ppb_ram #(
        .WIDTH ($bits(pkt_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (head_pkt)
    );

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign ram_rd_en = (state_reg == ST_READ);

    assign stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.bytes_zero = (bytes_reg == '0);

    // Budget refill multiplies, one per stage
    assign base_prod  = job_reg.item.rate_kbps * job_reg.item.interval_ms;
    assign scale_prod = mul_reg[47:3] * cfg.budget_margin_q8;
    assign refill_c   = (scale_prod[54:8+REFILL_W] != '0) ? {REFILL_W{1'b1}}
                                                         : scale_prod[8+REFILL_W-1:8];

    // Frame delay product from the head arrival time
    assign diff     = head_pkt.stored - last_stored_reg;
    assign fac_prod = cfg.frame_factor_q8 * diff;

    // Tail slot of the packet queue
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail     = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                    : PTR_W'(tail_sum);

    assign out_free = !out_valid_reg || out_ready;
    assign done_go  = (state_reg == ST_DONE) && out_free;
    assign full     = stat.full;

    // Release decision for a request
    assign elapsed  = job_reg.item.now_ms - last_sent_reg;
    assign gap_ok   = (elapsed >= {24'd0, cfg.packet_gap_ms});
    assign fac_ok   = ({2'b00, elapsed, 8'd0} >= prod_reg);
    assign can_send = !stat.bytes_zero && !stat.empty;
    assign ok       = job_reg.op.request && can_send &&
                      ((budget_reg > 0) ||
                       ((last_len_reg != '0) &&
                        ((head_pkt.stamp == last_stamp_reg) ? gap_ok : fac_ok)));
    assign len_ext  = BYTES_W'(head_pkt.len);

    assign ram_wr_en   = done_go && job_reg.op.fill && !full;
    assign ram_wr_data = '{seq:    job_reg.item.seq_num,
                           stamp:  job_reg.item.frame_stamp,
                           len:    job_reg.item.packet_bytes,
                           stored: job_reg.item.now_ms};

    // Sequence the command and commit its effects
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        bytes_next       = bytes_reg;
        budget_next      = budget_reg;
        last_stamp_next  = last_stamp_reg;
        last_len_next    = last_len_reg;
        last_stored_next = last_stored_reg;
        last_sent_next   = last_sent_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.op.update)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (job.op.request)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (job_reg.op.fill && !full)
                    begin
                        count_next = count_reg + 1'b1;
                        bytes_next = bytes_reg + BYTES_W'(job_reg.item.packet_bytes);
                    end
                    if (job_reg.op.update)
                    begin
                        if (budget_reg < 0)
                        begin
                            budget_next = sat_budget(
                                {budget_reg[BUDGET_W-1], budget_reg} +
                                $signed({2'b00, refill_reg}));
                        end
                        else
                        begin
                            budget_next = $signed({1'b0, refill_reg});
                        end
                    end
                    if (ok)
                    begin
                        budget_next = sat_budget(
                            {budget_reg[BUDGET_W-1], budget_reg} -
                            $signed({19'd0, head_pkt.len}));
                        bytes_next  = bytes_reg - ((bytes_reg >= len_ext) ? len_ext : bytes_reg);
                        head_next   = (head_reg == PTR_W'(QUEUE_DEPTH - 1))
                                    ? '0 : head_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                        last_stamp_next  = head_pkt.stamp;
                        last_len_next    = head_pkt.len;
                        last_stored_next = head_pkt.stored;
                        last_sent_next   = job_reg.item.now_ms;
                    end
                    if (job_reg.op.clear)
                    begin
                        head_next   = '0;
                        count_next  = '0;
                        bytes_next  = '0;
                        budget_next = '0;
                    end
                    out_valid_next            = 1'b1;
                    out_data_next.sent        = ok;
                    out_data_next.sent_seq    = ok ? head_pkt.seq : 16'd0;
                    out_data_next.queue_empty = (count_next == '0);
                    out_data_next.dropped     = job_reg.op.fill && full;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            bytes_reg       <= '0;
            budget_reg      <= '0;
            last_stamp_reg  <= '0;
            last_len_reg    <= '0;
            last_stored_reg <= '0;
            last_sent_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            bytes_reg       <= bytes_next;
            budget_reg      <= budget_next;
            last_stamp_reg  <= last_stamp_next;
            last_len_reg    <= last_len_next;
            last_stored_reg <= last_stored_next;
            last_sent_reg   <= last_sent_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture the beat and the arithmetic stages
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_MUL)
        begin
            mul_reg <= base_prod;
        end
        if (state_reg == ST_SCALE)
        begin
            refill_reg <= refill_c;
        end
        if (state_reg == ST_EVAL)
        begin
            prod_reg <= fac_prod;
        end
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/packet_pacing_bucket.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data (in_t)
// out       output     out_valid/out_ready  out_data (out_t)
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A beat crosses a two-entry command queue before the executing sequencer.
// Fill and clear go straight to the result state; update passes the two multiply
// stages of the budget refill and request the registered packet memory read.
// Reset clears queue pointers, byte counts, the budget and the last-sent record.
// A stalled result holds the sequencer; the command queue keeps taking beats until both entries are full.
module packet_pacing_bucket
    import ppb_pkg::*;
    #(
        parameter int QUEUE_DEPTH = 64
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       in_valid,
        output logic       in_ready,
        input  in_t        in_data,
        output logic       out_valid,
        input  logic       out_ready,
        output out_t       out_data,
        input  logic       cfg_valid,
        output logic       cfg_ready,
        input  logic [1:0] cfg_index,
        input  logic [9:0] cfg_data
    );

    cfg_t  cfg_reg, cfg_next;
    logic  job_valid;
    logic  job_ready;
    job_t  job;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PACKET_GAP:    cfg_next.packet_gap_ms    = cfg_data[7:0];
                REG_FRAME_FACTOR:  cfg_next.frame_factor_q8  = cfg_data;
                REG_BUDGET_MARGIN: cfg_next.budget_margin_q8 = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{packet_gap_ms:    PACKET_GAP_RESET,
                         frame_factor_q8:  FRAME_FACTOR_RESET,
                         budget_margin_q8: BUDGET_MARGIN_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ppb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ppb_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .stat      (stat)
    );

    // An empty queue holds no bytes
    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> stat.bytes_zero)
        else $error("queue empty with bytes pending");

    // A full queue is never empty
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue both full and empty");

    // A dropped fill neither sends nor reports an empty queue
    a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.dropped |-> !out_data.sent && !out_data.queue_empty)
        else $error("inconsistent drop result");

    // A send result never leaves the queue full
    a_send_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && out_data.sent |-> !stat.full)
        else $error("send left queue full");

endmodule
